FILE: rtl/isma_pkg.sv
// ----------------------------------------------------------------------------
// isma_pkg: shared constants for the interval stopwatch
// Field widths of the input and result beats, the nanosecond wrap constant
// and the default averaging window depth.
// ----------------------------------------------------------------------------
package isma_pkg;

  // Input beat field widths
  localparam int unsigned SEC_W      = 32;
  localparam int unsigned NSEC_W     = 30;

  // Result beat field widths
  localparam int unsigned IVL_SEC_W  = 33;
  localparam int unsigned CNT_OUT_W  = 4;

  // Nanoseconds in one second
  localparam logic [NSEC_W-1:0] NSEC_PER_SEC = 30'd1000000000;

  // Default depth of the averaging window
  localparam int unsigned WINDOW_DEF = 10;

endpackage

FILE: rtl/isma_in_if.sv
// ----------------------------------------------------------------------------
// isma_in_if: timing mark channel
// Valid/ready channel carrying one timestamp per beat.
// ----------------------------------------------------------------------------
interface isma_in_if;

  logic                           valid;
  logic                           ready;
  logic [isma_pkg::SEC_W-1:0]     stamp_sec;
  logic [isma_pkg::NSEC_W-1:0]    stamp_nsec;

  modport source (output valid, output stamp_sec, output stamp_nsec, input ready);
  modport sink   (input valid, input stamp_sec, input stamp_nsec, output ready);

endinterface

FILE: rtl/isma_out_if.sv
// ----------------------------------------------------------------------------
// isma_out_if: stopwatch result channel
// Valid/ready channel carrying the latest interval and the window averages.
// ----------------------------------------------------------------------------
interface isma_out_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 interval_done;
  logic signed [isma_pkg::IVL_SEC_W-1:0] last_sec;
  logic [isma_pkg::NSEC_W-1:0]          last_nsec;
  logic [isma_pkg::CNT_OUT_W-1:0]       sample_count;
  logic signed [isma_pkg::IVL_SEC_W-1:0] avg_sec;
  logic [isma_pkg::NSEC_W-1:0]          avg_nsec;
  logic                                 avg_valid;

  modport source (output valid, output interval_done, output last_sec, output last_nsec,
                  output sample_count, output avg_sec, output avg_nsec, output avg_valid,
                  input ready);
  modport sink   (input valid, input interval_done, input last_sec, input last_nsec,
                  input sample_count, input avg_sec, input avg_nsec, input avg_valid,
                  output ready);

endinterface

FILE: rtl/isma_ram.sv
// ----------------------------------------------------------------------------
// isma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module isma_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/interval_stopwatch_moving_average_top.sv
// ----------------------------------------------------------------------------
// interval_stopwatch_moving_average_top: interval timer with moving average
// Marks alternate start/stop. A stop mark forms end minus start (with a
// nanosecond borrow), pushes it into a window RAM of the last WINDOW
// intervals, then re-sums the window and divides each component by the
// count on one shared restoring divider.
//
//   channel  dir  modport  payload
//   in_i     in   sink     stamp_sec, stamp_nsec
//   res_o    out  source   interval_done, last_sec, last_nsec, sample_count,
//                          avg_sec, avg_nsec, avg_valid
//
// Start mark: accept, then load the result register.
// Stop mark: form the interval, sweep the n intervals held (one RAM read
//   a cycle), then run the 1-bit-per-cycle divider over DivW =
//   33 + clog2(WINDOW + 1) bits, once for seconds and once for
//   nanoseconds, and load the result register.
// Reset clears all control state; the window RAM needs no clearing pass.
// The result register decouples the sides: a new mark is taken while a
// result still waits; a stalled result holds only the finishing step.
// ----------------------------------------------------------------------------
module interval_stopwatch_moving_average_top #(
  parameter int unsigned WINDOW = isma_pkg::WINDOW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  isma_in_if.sink   in_i,
  isma_out_if.source res_o
);

  import isma_pkg::*;

  // Derived widths
  localparam int unsigned AddrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumSW = IVL_SEC_W + CntW;
  localparam int unsigned SumNW = NSEC_W + CntW;
  localparam int unsigned DivW  = SumSW;
  localparam int unsigned DivCW = $clog2(DivW);
  localparam int unsigned RamW  = IVL_SEC_W + NSEC_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic                        await_q, await_d;
  logic [SEC_W-1:0]            start_sec_q, start_sec_d;
  logic [NSEC_W-1:0]           start_nsec_q, start_nsec_d;
  logic signed [IVL_SEC_W-1:0] latest_sec_q, latest_sec_d;
  logic [NSEC_W-1:0]           latest_nsec_q, latest_nsec_d;
  logic [AddrW-1:0]            slot_q, slot_d;
  logic [CntW-1:0]             held_q, held_d;
  logic                        done_q, done_d;
  logic signed [IVL_SEC_W-1:0] avg_sec_q, avg_sec_d;
  logic [NSEC_W-1:0]           avg_nsec_q, avg_nsec_d;

  logic [CntW-1:0]             rd_cnt_q, rd_cnt_d;
  logic                        rd_pend_q, rd_pend_d;
  logic signed [SumSW-1:0]     acc_s_q, acc_s_d;
  logic [SumNW-1:0]            acc_ns_q, acc_ns_d;

  logic [DivW-1:0]             quo_q, quo_d;
  logic [CntW-1:0]             rem_q, rem_d;
  logic [DivCW-1:0]            div_cnt_q, div_cnt_d;
  logic                        neg_q, neg_d;

  logic                        out_valid_q, out_valid_d;

  // Accepted beat
  logic acc_beat;
  assign in_i.ready = (state_q == S_IDLE);
  assign acc_beat   = in_i.valid && in_i.ready;

  // Interval arithmetic: end minus start, borrow a second on negative nsec
  logic [NSEC_W:0]    dns_raw, dns_adj;
  logic               borrow;
  logic [NSEC_W-1:0]  ivl_nsec;
  logic [IVL_SEC_W-1:0] ivl_sec;

  assign dns_raw  = {1'b0, in_i.stamp_nsec} - {1'b0, start_nsec_q};
  assign borrow   = dns_raw[NSEC_W];
  assign dns_adj  = dns_raw + {1'b0, NSEC_PER_SEC};
  assign ivl_nsec = borrow ? dns_adj[NSEC_W-1:0] : dns_raw[NSEC_W-1:0];
  assign ivl_sec  = {1'b0, in_i.stamp_sec} - {1'b0, start_sec_q}
                  - {{(IVL_SEC_W-1){1'b0}}, borrow};

  // Window RAM
  logic             ram_we;
  logic [RamW-1:0]  ram_rdata;
  logic [IVL_SEC_W-1:0] rd_sec;
  logic [NSEC_W-1:0]    rd_nsec;

  assign ram_we = acc_beat && !await_q;
  assign rd_sec  = ram_rdata[RamW-1:NSEC_W];
  assign rd_nsec = ram_rdata[NSEC_W-1:0];

  isma_ram #(
    .Width (RamW),
    .Depth (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({ivl_sec, ivl_nsec}),
    .raddr_i (rd_cnt_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared restoring divider step: one quotient bit per cycle
  logic [CntW:0]   trial;
  logic [CntW:0]   den;
  logic            ge;
  logic [CntW:0]   trial_sub;
  logic [CntW-1:0] rem_step;
  logic [DivW-1:0] quo_step;
  logic [DivW-1:0] quo_neg;
  logic            div_last;

  assign trial     = {rem_q, quo_q[DivW-1]};
  assign den       = {1'b0, held_q};
  assign ge        = (trial >= den);
  assign trial_sub = trial - den;
  assign rem_step  = ge ? trial_sub[CntW-1:0] : trial[CntW-1:0];
  assign quo_step  = {quo_q[DivW-2:0], ge};
  assign quo_neg   = ~quo_step + {{(DivW-1){1'b0}}, 1'b1};
  assign div_last  = (div_cnt_q == DivCW'(DivW - 1));

  // Window sweep
  logic rd_issue;
  assign rd_issue = (rd_cnt_q < held_q);

  // Magnitude of the seconds sum
  logic [SumSW-1:0] sum_s_mag;
  assign sum_s_mag = acc_s_q[SumSW-1] ? (~acc_s_q + {{(SumSW-1){1'b0}}, 1'b1})
                                      : acc_s_q;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    await_d       = await_q;
    start_sec_d   = start_sec_q;
    start_nsec_d  = start_nsec_q;
    latest_sec_d  = latest_sec_q;
    latest_nsec_d = latest_nsec_q;
    slot_d        = slot_q;
    held_d        = held_q;
    done_d        = done_q;
    avg_sec_d     = avg_sec_q;
    avg_nsec_d    = avg_nsec_q;
    rd_cnt_d      = rd_cnt_q;
    rd_pend_d     = 1'b0;
    acc_s_d       = acc_s_q;
    acc_ns_d      = acc_ns_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    div_cnt_d     = div_cnt_q;
    neg_d         = neg_q;
    out_valid_d   = out_valid_q;

    // Drop the result beat once taken
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (acc_beat) begin
          if (await_q) begin
            // Latch the start mark
            start_sec_d  = in_i.stamp_sec;
            start_nsec_d = in_i.stamp_nsec;
            await_d      = 1'b0;
            done_d       = 1'b0;
            state_d      = S_OUT;
          end else begin
            // Close the interval and push it into the window
            latest_sec_d  = ivl_sec;
            latest_nsec_d = ivl_nsec;
            start_sec_d   = '0;
            start_nsec_d  = '0;
            await_d       = 1'b1;
            done_d        = 1'b1;
            slot_d        = (slot_q == AddrW'(WINDOW - 1)) ? '0
                          : slot_q + {{(AddrW-1){1'b0}}, 1'b1};
            if (held_q < CntW'(WINDOW)) begin
              held_d = held_q + {{(CntW-1){1'b0}}, 1'b1};
            end
            rd_cnt_d = '0;
            acc_s_d  = '0;
            acc_ns_d = '0;
            state_d  = S_SUM;
          end
        end
      end

      S_SUM: begin
        // Issue one read a cycle, add its data in the cycle after
        if (rd_issue) begin
          rd_cnt_d  = rd_cnt_q + {{(CntW-1){1'b0}}, 1'b1};
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          acc_s_d  = acc_s_q + SumSW'($signed(rd_sec));
          acc_ns_d = acc_ns_q + SumNW'(rd_nsec);
        end
        if (!rd_issue && !rd_pend_q) begin
          quo_d     = sum_s_mag;
          rem_d     = '0;
          div_cnt_d = '0;
          neg_d     = acc_s_q[SumSW-1];
          state_d   = S_DIVS;
        end
      end

      S_DIVS: begin
        quo_d     = quo_step;
        rem_d     = rem_step;
        div_cnt_d = div_cnt_q + {{(DivCW-1){1'b0}}, 1'b1};
        if (div_last) begin
          // Restore the sign, then divide the nanoseconds sum
          avg_sec_d = neg_q ? quo_neg[IVL_SEC_W-1:0] : quo_step[IVL_SEC_W-1:0];
          quo_d     = DivW'(acc_ns_q);
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = S_DIVN;
        end
      end

      S_DIVN: begin
        quo_d     = quo_step;
        rem_d     = rem_step;
        div_cnt_d = div_cnt_q + {{(DivCW-1){1'b0}}, 1'b1};
        if (div_last) begin
          avg_nsec_d = quo_step[NSEC_W-1:0];
          state_d    = S_OUT;
        end
      end

      S_OUT: begin
        // Load the result register when it is free
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      await_q       <= 1'b1;
      start_sec_q   <= '0;
      start_nsec_q  <= '0;
      latest_sec_q  <= '0;
      latest_nsec_q <= '0;
      slot_q        <= '0;
      held_q        <= '0;
      done_q        <= 1'b0;
      avg_sec_q     <= '0;
      avg_nsec_q    <= '0;
      rd_cnt_q      <= '0;
      rd_pend_q     <= 1'b0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      await_q       <= await_d;
      start_sec_q   <= start_sec_d;
      start_nsec_q  <= start_nsec_d;
      latest_sec_q  <= latest_sec_d;
      latest_nsec_q <= latest_nsec_d;
      slot_q        <= slot_d;
      held_q        <= held_d;
      done_q        <= done_d;
      avg_sec_q     <= avg_sec_d;
      avg_nsec_q    <= avg_nsec_d;
      rd_cnt_q      <= rd_cnt_d;
      rd_pend_q     <= rd_pend_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_s_q  <= acc_s_d;
    acc_ns_q <= acc_ns_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
  end

  // Result register
  logic [CntW+CNT_OUT_W-1:0] held_ext;
  assign held_ext = {{CNT_OUT_W{1'b0}}, held_q};

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || res_o.ready)) begin
      res_o.interval_done <= done_q;
      res_o.last_sec      <= latest_sec_q;
      res_o.last_nsec     <= latest_nsec_q;
      res_o.sample_count  <= held_ext[CNT_OUT_W-1:0];
      res_o.avg_sec       <= avg_sec_q;
      res_o.avg_nsec      <= avg_nsec_q;
      res_o.avg_valid     <= (held_q != '0);
    end
  end

  assign res_o.valid = out_valid_q;

`ifndef SYNTHESIS
  // Window count never exceeds the depth
  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(WINDOW))
    else $error("window count above depth");

  // Write slot stays inside the window
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, slot_q} < (AddrW+1)'(WINDOW))
    else $error("write slot out of range");

  // A start mark goes straight to the result step
  a_start_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_beat && await_q) |=> (state_q == S_OUT))
    else $error("start mark did not bypass averaging");

  // A stop mark always leaves a nonempty window to sweep
  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_beat && !await_q) |=> (state_q == S_SUM && held_q != '0))
    else $error("stop mark left empty window");

  // The divider runs only over a nonzero count
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVS || state_q == S_DIVN) |-> (held_q != '0))
    else $error("divide by zero count");
`endif

endmodule
